// File: sv/pss_pkg.sv
// Shared types, constants and list functions for the subscription table.
package pss_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int TOPIC_SLOTS = 4;
	localparam int RESULT_CAP  = 16;
	localparam int K_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int N_W   = $clog2(RESULT_CAP + 1);

	typedef enum logic [3:0] {
		OP_R_SUB   = 4'd0,
		OP_R_UNSUB = 4'd1,
		OP_R_ADV   = 4'd2,
		OP_R_UNADV = 4'd3,
		OP_L_SUB   = 4'd4,
		OP_L_UNSUB = 4'd5,
		OP_L_ADV   = 4'd6,
		OP_L_UNADV = 4'd7,
		OP_NODE_WR = 4'd8,
		OP_TBL_WR  = 4'd9,
		OP_LOOKUP  = 4'd10
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_SUB   = 2'd0,
		KIND_UNSUB = 2'd1,
		KIND_ADV   = 2'd2,
		KIND_UNADV = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_DELIVER  = 3'd1,
		ST_NOT_PUB  = 3'd2,
		ST_FULL     = 3'd3,
		ST_OWN_MISS = 3'd4
	} status_t;

	typedef struct packed {
		logic [3:0]        opcode;
		logic [31:0]       sender_address;
		logic [31:0]       node_address;
		logic signed [7:0] topic;
		logic [63:0]       topic_lists;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] subscriber_address;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] pub;
		logic [31:0] sub;
	} entry_t;

	localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;

	function automatic logic list_has(input logic [31:0] w, input logic [7:0] t);
		logic r;
		r = 1'b0;
		for (int s = 0; s < TOPIC_SLOTS; s++) begin
			if (w[8*s +: 8] == t) r = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [31:0] list_insert(input logic [31:0] w, input logic [7:0] t);
		logic [31:0] r;
		logic stop;
		r = w;
		stop = 1'b0;
		for (int s = 0; s < TOPIC_SLOTS; s++) begin
			if (!stop && w[8*s +: 8] == t) begin
				stop = 1'b1;
			end else if (!stop && w[8*s +: 8] == 8'hFF) begin
				r[8*s +: 8] = t;
				stop = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] list_remove(input logic [31:0] w, input logic [7:0] t);
		logic [31:0] r;
		logic hit;
		r = w;
		hit = 1'b0;
		for (int s = 0; s < TOPIC_SLOTS - 1; s++) begin
			if (w[8*s +: 8] == t) hit = 1'b1;
			if (hit) r[8*s +: 8] = w[8*(s+1) +: 8];
		end
		if (w[8*(TOPIC_SLOTS-1) +: 8] == t) hit = 1'b1;
		if (hit) r[8*(TOPIC_SLOTS-1) +: 8] = 8'hFF;
		return r;
	endfunction

endpackage

// File: sv/pubsub_subscription_table.sv
// Subscription table top level: ring of entry cells with a head processor.
//
// Input channel in_valid/in_stall/in_data carries one operation per beat;
// the block stalls the input while an operation is under way. Output
// channel out_valid/out_stall/out_data carries result beats, the final
// beat of each operation marked by last. The configuration channel
// cfg_valid/cfg_ready/cfg_data writes own_address; cfg_ready is always high.
// The entries sit in a ring of TABLE_DEPTH cells that rotates one place per
// cycle past the head while a pass runs and no result is stalled.
// Updates and record writes take one pass over the table. A publish lookup
// takes two passes (own entry check, then subscriber scan), and stops after
// the first if the own entry is missing or does not publish the topic.
// A result waiting in the output register with out_stall high freezes the
// ring; nothing is lost. Reset clears own_address, the entry count and all
// control state; entry contents need no reset since only entries below the
// count are looked at.
module pubsub_subscription_table
	import pss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PASS1 = 4'b0010,
		S_PASS2 = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [31:0]       own_q;
	logic [CNT_W-1:0]  count_q;
	logic [K_W-1:0]    k_q;
	logic [31:0]       key_q;
	logic [7:0]        topic_q;
	logic [63:0]       rec_q;
	logic              active_q;
	logic              isrec_q;
	logic              islook_q;
	kind_t             kind_q;
	logic              found_q;
	logic              has_q;
	status_t           fin_q;
	logic              pend_valid_q;
	logic [31:0]       pend_addr_q;
	logic [N_W-1:0]    n_q;
	logic              out_valid_q;
	out_t              out_q;

	entry_t cell_q [TABLE_DEPTH];
	entry_t head;
	entry_t head_next;
	entry_t new_entry;
	logic   can_push;
	logic   step;
	logic   head_valid;
	logic   head_hit;
	logic   at_count;
	logic   last_k;
	logic   found_now;
	logic   has_now;
	logic   sub_hit;
	logic   in_fire;
	logic [31:0] single;

	assign head       = cell_q[0];
	assign can_push   = !out_valid_q || !out_stall;
	assign step       = (state_q == S_PASS1 || state_q == S_PASS2) && can_push;
	assign head_valid = CNT_W'(k_q) < count_q;
	assign head_hit   = head_valid && head.key == key_q;
	assign at_count   = CNT_W'(k_q) == count_q;
	assign last_k     = k_q == K_W'(TABLE_DEPTH - 1);
	assign found_now  = found_q || head_hit;
	assign has_now    = has_q || (head_hit && list_has(head.pub, topic_q));
	assign sub_hit    = head_valid && head.key != key_q && list_has(head.sub, topic_q)
		&& n_q < N_W'(RESULT_CAP);
	assign single     = {24'hFF_FFFF, topic_q};
	assign in_fire    = in_valid && !in_stall;

	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		new_entry.key = key_q;
		new_entry.pub = EMPTY_WORD;
		new_entry.sub = EMPTY_WORD;
		if (isrec_q) begin
			new_entry.pub = rec_q[31:0];
			new_entry.sub = rec_q[63:32];
		end else if (kind_q == KIND_SUB) begin
			new_entry.sub = single;
		end else if (kind_q == KIND_ADV) begin
			new_entry.pub = single;
		end
	end

	always_comb begin
		head_next = head;
		if (state_q == S_PASS1 && active_q) begin
			if (head_hit && !found_q) begin
				if (isrec_q) begin
					head_next.pub = rec_q[31:0];
					head_next.sub = rec_q[63:32];
				end else begin
					unique case (kind_q)
						KIND_SUB:   head_next.sub = list_insert(head.sub, topic_q);
						KIND_UNSUB: head_next.sub = list_remove(head.sub, topic_q);
						KIND_ADV:   head_next.pub = list_insert(head.pub, topic_q);
						KIND_UNADV: head_next.pub = list_remove(head.pub, topic_q);
						default:    head_next = head;
					endcase
				end
			end else if (at_count && !found_q) begin
				head_next = new_entry;
			end
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
		entry_t d_i;
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign d_i = head_next;
		end else begin : g_mid
			assign d_i = cell_q[i+1];
		end
		pss_cell u_cell (
			.clk   (clk),
			.shift (step),
			.d     (d_i),
			.q     (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			topic_q <= in_data.topic;
			rec_q   <= in_data.topic_lists;
			kind_q  <= kind_t'(in_data.opcode[1:0]);
			isrec_q <= in_data.opcode == OP_NODE_WR || in_data.opcode == OP_TBL_WR;
			if ((in_data.opcode >= OP_L_SUB && in_data.opcode <= OP_L_UNADV)
				|| in_data.opcode == OP_LOOKUP) begin
				key_q <= own_q;
			end else begin
				key_q <= in_data.node_address;
			end
		end
		if (step && state_q == S_PASS2 && sub_hit) begin
			pend_addr_q <= head.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			k_q          <= '0;
			active_q     <= 1'b0;
			islook_q     <= 1'b0;
			found_q      <= 1'b0;
			has_q        <= 1'b0;
			fin_q        <= ST_DONE;
			pend_valid_q <= 1'b0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q      <= S_PASS1;
						k_q          <= '0;
						found_q      <= 1'b0;
						has_q        <= 1'b0;
						pend_valid_q <= 1'b0;
						n_q          <= '0;
						fin_q        <= ST_DONE;
						islook_q     <= in_data.opcode == OP_LOOKUP;
						priority if (in_data.opcode <= OP_R_UNSUB) begin
							active_q <= in_data.sender_address != own_q;
						end else if (in_data.opcode <= OP_NODE_WR) begin
							active_q <= 1'b1;
						end else if (in_data.opcode == OP_TBL_WR) begin
							active_q <= in_data.node_address != own_q;
						end else begin
							active_q <= 1'b0;
						end
					end
				end
				S_PASS1: begin
					if (step) begin
						found_q <= found_now;
						has_q   <= has_now;
						k_q     <= k_q + K_W'(1);
						if (last_k) begin
							k_q <= '0;
							if (islook_q) begin
								priority if (!found_now) begin
									fin_q   <= ST_OWN_MISS;
									state_q <= S_DONE;
								end else if (!has_now) begin
									fin_q   <= ST_NOT_PUB;
									state_q <= S_DONE;
								end else begin
									state_q <= S_PASS2;
								end
							end else begin
								state_q <= S_DONE;
								if (active_q && !found_now) begin
									if (count_q == CNT_W'(TABLE_DEPTH)) begin
										fin_q <= ST_FULL;
									end else begin
										count_q <= count_q + CNT_W'(1);
									end
								end
							end
						end
					end
				end
				S_PASS2: begin
					if (step) begin
						k_q <= k_q + K_W'(1);
						if (sub_hit) begin
							pend_valid_q <= 1'b1;
							n_q          <= n_q + N_W'(1);
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_q       <= '{ST_DELIVER, pend_addr_q, 1'b0};
							end
						end
						if (last_k) begin
							k_q     <= '0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (can_push) begin
						out_valid_q <= 1'b1;
						if (pend_valid_q) begin
							out_q <= '{ST_DELIVER, pend_addr_q, 1'b1};
						end else begin
							out_q <= '{fin_q, 32'd0, 1'b1};
						end
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_PASS1)
		else $error("accepted beat did not start a pass");

	a_pend_place: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == S_PASS2 || state_q == S_DONE))
		else $error("pending subscriber outside lookup scan");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q) == S_PASS1)
		else $error("entry count changed outside a pass");

	a_ring_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !step)
		else $error("ring moved while a result was stalled");

endmodule

// File: sv/pss_cell.sv
// One table cell: holds an entry and passes it to its neighbor on each shift.
module pss_cell
	import pss_pkg::*;
(
	input  logic   clk,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// File: tb/sv/pubsub_subscription_table_test.sv
// Testbench for the subscription table: directed and random operations checked against a table model.
module pubsub_subscription_table_test;
	import pss_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	pubsub_subscription_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// table model
	logic [31:0] tbl_key [TABLE_DEPTH];
	logic [31:0] tbl_pub [TABLE_DEPTH];
	logic [31:0] tbl_sub [TABLE_DEPTH];
	int          tbl_count;
	logic [31:0] own_addr;

	out_t pending_results[$];
	int   errors;
	int   send_idle_pct;
	int   recv_idle_pct;
	logic [31:0] addr_pool [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] slot_insert(logic [31:0] w, logic [7:0] t);
		for (int s = 0; s < TOPIC_SLOTS; s++) begin
			if (w[8*s +: 8] == t) return w;
			if (w[8*s +: 8] == 8'hFF) begin
				w[8*s +: 8] = t;
				return w;
			end
		end
		return w;
	endfunction

	function automatic logic [31:0] slot_remove(logic [31:0] w, logic [7:0] t);
		for (int s = 0; s < TOPIC_SLOTS; s++) begin
			if (w[8*s +: 8] == t) begin
				for (int k = s; k < TOPIC_SLOTS - 1; k++) w[8*k +: 8] = w[8*(k+1) +: 8];
				w[8*(TOPIC_SLOTS-1) +: 8] = 8'hFF;
				return w;
			end
		end
		return w;
	endfunction

	function automatic bit slot_holds(logic [31:0] w, logic [7:0] t);
		for (int s = 0; s < TOPIC_SLOTS; s++)
			if (w[8*s +: 8] == t) return 1'b1;
		return 1'b0;
	endfunction

	function automatic int entry_of(logic [31:0] key);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_key[i] == key) return i;
		return -1;
	endfunction

	function automatic status_t entry_create(logic [31:0] key, logic [31:0] p,
			logic [31:0] s);
		if (tbl_count >= TABLE_DEPTH) return ST_FULL;
		tbl_key[tbl_count] = key;
		tbl_pub[tbl_count] = p;
		tbl_sub[tbl_count] = s;
		tbl_count++;
		return ST_DONE;
	endfunction

	function automatic void push_result(status_t st, logic [31:0] a, logic l);
		out_t r;
		r.status = st;
		r.subscriber_address = a;
		r.last = l;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_table_op(in_t it);
		status_t st;
		int idx;
		int n;
		logic [31:0] key;
		logic [31:0] single;
		logic [1:0] kind;
		st = ST_DONE;
		single = {24'hFFFFFF, it.topic};
		kind = it.opcode[1:0];
		if (it.opcode <= OP_L_UNADV) begin
			key = (it.opcode >= OP_L_SUB) ? own_addr : it.node_address;
			if (it.opcode <= OP_R_UNSUB && it.sender_address == own_addr) begin
				push_result(ST_DONE, 32'd0, 1'b1);
				return;
			end
			idx = entry_of(key);
			if (idx >= 0) begin
				case (kind)
					KIND_SUB:   tbl_sub[idx] = slot_insert(tbl_sub[idx], it.topic);
					KIND_UNSUB: tbl_sub[idx] = slot_remove(tbl_sub[idx], it.topic);
					KIND_ADV:   tbl_pub[idx] = slot_insert(tbl_pub[idx], it.topic);
					default:    tbl_pub[idx] = slot_remove(tbl_pub[idx], it.topic);
				endcase
			end else begin
				case (kind)
					KIND_SUB: st = entry_create(key, EMPTY_WORD, single);
					KIND_ADV: st = entry_create(key, single, EMPTY_WORD);
					default:  st = entry_create(key, EMPTY_WORD, EMPTY_WORD);
				endcase
			end
			push_result(st, 32'd0, 1'b1);
		end else if (it.opcode == OP_NODE_WR || it.opcode == OP_TBL_WR) begin
			if (!(it.opcode == OP_TBL_WR && it.node_address == own_addr)) begin
				idx = entry_of(it.node_address);
				if (idx >= 0) begin
					tbl_pub[idx] = it.topic_lists[31:0];
					tbl_sub[idx] = it.topic_lists[63:32];
				end else begin
					st = entry_create(it.node_address, it.topic_lists[31:0],
						it.topic_lists[63:32]);
				end
			end
			push_result(st, 32'd0, 1'b1);
		end else if (it.opcode == OP_LOOKUP) begin
			idx = entry_of(own_addr);
			if (idx < 0) push_result(ST_OWN_MISS, 32'd0, 1'b1);
			else if (!slot_holds(tbl_pub[idx], it.topic)) push_result(ST_NOT_PUB, 32'd0, 1'b1);
			else begin
				n = 0;
				for (int i = 0; i < tbl_count; i++) begin
					if (n < RESULT_CAP && tbl_key[i] != own_addr
							&& slot_holds(tbl_sub[i], it.topic)) begin
						push_result(ST_DELIVER, tbl_key[i], 1'b0);
						n++;
					end
				end
				if (n == 0) push_result(ST_DONE, 32'd0, 1'b1);
				else pending_results[$].last = 1'b1;
			end
		end else begin
			push_result(ST_DONE, 32'd0, 1'b1);
		end
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (out_data.status !== want.status
							|| out_data.subscriber_address !== want.subscriber_address
							|| out_data.last !== want.last) begin
						$display("%0t: mismatch, expected %h, actual %h", $time, want, out_data);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_op(in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_table_op(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * TABLE_DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_own(logic [31:0] a);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= a;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		own_addr = a;
	endtask

	function automatic in_t make_op(opcode_t op, logic [31:0] snd, logic [31:0] nd,
			logic [7:0] t, logic [63:0] lists);
		in_t it;
		it.opcode = op;
		it.sender_address = snd;
		it.node_address = nd;
		it.topic = t;
		it.topic_lists = lists;
		return it;
	endfunction

	task automatic test_directed();
		send_op(make_op(OP_LOOKUP, 32'd1, 32'd2, 8'd5, 64'd0));
		send_op(make_op(OP_L_ADV, 32'd0, 32'd0, 8'd5, 64'd0));
		send_op(make_op(OP_LOOKUP, 32'd1, 32'd2, 8'd6, 64'd0));
		send_op(make_op(OP_LOOKUP, 32'd1, 32'd2, 8'd5, 64'd0));
		send_op(make_op(OP_R_SUB, 32'd0, 32'd7, 8'd5, 64'd0));
		send_op(make_op(OP_R_SUB, 32'd9, 32'hFFFF_FFFF, 8'd5, 64'd0));
		send_op(make_op(OP_R_ADV, 32'd9, 32'd3, 8'h80, 64'd0));
		send_op(make_op(OP_R_UNADV, 32'd9, 32'd4, 8'h7F, 64'd0));
		send_op(make_op(OP_R_UNSUB, 32'd9, 32'd5, 8'hFF, 64'd0));
		send_op(make_op(OP_L_SUB, 32'd0, 32'd0, 8'd5, 64'd0));
		send_op(make_op(OP_L_UNSUB, 32'd0, 32'd0, 8'd5, 64'd0));
		send_op(make_op(OP_L_UNADV, 32'd0, 32'd0, 8'd9, 64'd0));
		send_op(make_op(OP_NODE_WR, 32'd0, 32'd6, 8'd0,
			64'h0504_03FF_FFFF_FF05));
		send_op(make_op(OP_TBL_WR, 32'd0, 32'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
		send_op(make_op(OP_TBL_WR, 32'd0, 32'h8000_0000, 8'd0, 64'hFFFF_FF05_0000_0000));
		send_op(make_op(OP_LOOKUP, 32'd0, 32'd0, 8'd5, 64'd0));
		send_op(make_op(opcode_t'(4'd15), 32'd0, 32'd0, 8'd0, 64'd0));
		for (int i = 0; i < 4; i++)
			send_op(make_op(OP_L_ADV, 32'd0, 32'd0, 8'(10 + i), 64'd0));
		for (int i = 0; i < 4; i++)
			send_op(make_op(OP_L_UNADV, 32'd0, 32'd0, 8'(11 + i), 64'd0));
		drain();
	endtask

	task automatic test_full_table();
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			send_op(make_op(OP_R_SUB, 32'd1, 32'h100 + i, 8'd5, 64'd0));
		send_op(make_op(OP_L_ADV, 32'd0, 32'd0, 8'd5, 64'd0));
		send_op(make_op(OP_LOOKUP, 32'd0, 32'd0, 8'd5, 64'd0));
		drain();
	endtask

	task automatic test_random(int count);
		in_t it;
		int sel;
		for (int i = 0; i < count; i++) begin
			it.sender_address = ($urandom_range(3) == 0) ? own_addr : addr_pool[$urandom_range(7)];
			it.node_address = ($urandom_range(7) == 0) ? $urandom : addr_pool[$urandom_range(7)];
			it.topic = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
			it.topic_lists = ($urandom_range(1) == 0) ? {$urandom, $urandom}
				: {24'hFFFFFF, 6'd0, 2'($urandom), 24'hFFFFFF, 6'd0, 2'($urandom)};
			sel = $urandom_range(99);
			if (sel < 20) it.opcode = OP_LOOKUP;
			else if (sel < 30) it.opcode = OP_NODE_WR;
			else if (sel < 35) it.opcode = OP_TBL_WR;
			else if (sel < 37) it.opcode = 4'(11 + $urandom_range(4));
			else it.opcode = 4'($urandom_range(7));
			send_op(it);
			if (i == count / 2) drain();
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		tbl_count = 0;
		own_addr = 32'd0;
		send_idle_pct = 19;
		recv_idle_pct = 51;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_own(32'hFFFF_FFFF);
		test_directed();
		test_full_table();
		write_own(32'h0A00_0001);
		for (int i = 0; i < 8; i++) addr_pool[i] = (i < 2) ? 32'h0A00_0001 + i : $urandom;
		addr_pool[7] = 32'd0;
		send_idle_pct = 51;
		recv_idle_pct = 19;
		test_random(160);
		write_own(addr_pool[2]);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(160);
		write_own(32'h0000_0000);
		send_idle_pct = 19;
		recv_idle_pct = 51;
		test_random(160);
		if (errors == 0) $display("pubsub_subscription_table_test: PASS");
		else $display("pubsub_subscription_table_test: FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("pubsub_subscription_table_test: FAIL");
		$finish;
	end

endmodule

// File: sim.f
sv/pss_pkg.sv
sv/pss_cell.sv
sv/pubsub_subscription_table.sv
tb/sv/pubsub_subscription_table_test.sv
